[rtl/deq_pkg.sv]
// shared types and constants for the double-ended queue unit
package deq_pkg;

	localparam int DEPTH_DEF      = 16;
	localparam int DATA_WIDTH_DEF = 32;
	localparam int MODE_W         = 3;
	localparam int STATUS_W       = 2;

	typedef enum logic [MODE_W-1:0] {
		MODE_PUSH_FRONT = 3'd0,
		MODE_PUSH_REAR  = 3'd1,
		MODE_POP_FRONT  = 3'd2,
		MODE_POP_REAR   = 3'd3,
		MODE_PEEK_FRONT = 3'd4,
		MODE_PEEK_REAR  = 3'd5
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic exec;
	} ctl_cmd_t;

endpackage

[rtl/deq_ram.sv]
// generic single-port-write, single-port-read ram with registered read data
module deq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[rtl/deq_ctrl.sv]
// controller state machine: sequences load, execute and result phases
module deq_ctrl
	import deq_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	output logic     done,
	output ctl_cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_RESP
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_EXEC;
						busy_q  <= 1'b1;
					end
				end
				S_EXEC: begin
					state_q <= S_RESP;
					done_q  <= 1'b1;
				end
				S_RESP: begin
					state_q <= S_IDLE;
					done_q  <= 1'b0;
					busy_q  <= 1'b0;
				end
				default: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
					done_q  <= 1'b0;
				end
			endcase
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign cmd.load = start && !busy_q;
	assign cmd.exec = (state_q == S_EXEC);

	a_load_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> cmd.exec)
		else $error("transfer accepted but no execute cycle followed");

	a_exec_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> done && busy)
		else $error("execute cycle not followed by result strobe");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done && !busy)
		else $error("result strobe longer than one cycle");

endmodule

[rtl/deq_dp.sv]
// datapath: ring indices, fill count, slot memory and result registers
module deq_dp
	import deq_pkg::*;
#(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	localparam int AW = $clog2(DEPTH),
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ctl_cmd_t              cmd,
	input  logic [MODE_W-1:0]     mode,
	input  logic [DATA_WIDTH-1:0] data_in,
	output logic [DATA_WIDTH-1:0] data_out,
	output logic [STATUS_W-1:0]   status,
	output logic [CW-1:0]         count,
	output logic                  is_empty
);

	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	mode_t                 mode_q;
	logic [DATA_WIDTH-1:0] data_q;
	logic [AW-1:0]         head_q, tail_q;
	logic [CW-1:0]         fill_q;
	status_t               st_q;
	logic                  hit_q;

	logic [AW-1:0]         head_d, tail_d;
	logic [CW-1:0]         fill_d;
	status_t               st_d;
	logic                  hit_d;
	logic                  full, empty;
	logic [AW-1:0]         head_inc, head_dec, tail_inc, tail_dec;

	logic                  wr_en, rd_en;
	logic [AW-1:0]         wr_addr, rd_addr;
	logic [DATA_WIDTH-1:0] rd_data;

	assign full     = (fill_q == FULL_CNT);
	assign empty    = (fill_q == '0);
	assign head_inc = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
	assign head_dec = (head_q == '0) ? LAST_IDX : head_q - 1'b1;
	assign tail_inc = (tail_q == LAST_IDX) ? '0 : tail_q + 1'b1;
	assign tail_dec = (tail_q == '0) ? LAST_IDX : tail_q - 1'b1;

	always_comb begin
		head_d  = head_q;
		tail_d  = tail_q;
		fill_d  = fill_q;
		st_d    = ST_OK;
		hit_d   = 1'b0;
		wr_en   = 1'b0;
		rd_en   = 1'b0;
		wr_addr = head_dec;
		rd_addr = head_q;
		if (cmd.exec) begin
			unique case (mode_q)
				MODE_PUSH_FRONT, MODE_PUSH_REAR: begin
					if (full) begin
						st_d = ST_FULL;
					end else begin
						wr_en  = 1'b1;
						fill_d = fill_q + 1'b1;
						if (mode_q == MODE_PUSH_FRONT) begin
							wr_addr = head_dec;
							head_d  = head_dec;
						end else begin
							wr_addr = tail_q;
							tail_d  = tail_inc;
						end
					end
				end
				MODE_POP_FRONT, MODE_PEEK_FRONT: begin
					if (empty) begin
						st_d = ST_EMPTY;
					end else begin
						rd_en   = 1'b1;
						hit_d   = 1'b1;
						rd_addr = head_q;
						if (mode_q == MODE_POP_FRONT) begin
							head_d = head_inc;
							fill_d = fill_q - 1'b1;
						end
					end
				end
				MODE_POP_REAR, MODE_PEEK_REAR: begin
					if (empty) begin
						st_d = ST_EMPTY;
					end else begin
						rd_en   = 1'b1;
						hit_d   = 1'b1;
						rd_addr = tail_dec;
						if (mode_q == MODE_POP_REAR) begin
							tail_d = tail_dec;
							fill_d = fill_q - 1'b1;
						end
					end
				end
				// unused codes leave the indices and fill count as they are and report ST_OK
				default: begin
					st_d = ST_OK;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode_t'(mode);
			data_q <= data_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			fill_q <= '0;
			st_q   <= ST_OK;
			hit_q  <= 1'b0;
		end else if (cmd.exec) begin
			head_q <= head_d;
			tail_q <= tail_d;
			fill_q <= fill_d;
			st_q   <= st_d;
			hit_q  <= hit_d;
		end
	end

	deq_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(data_q),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign data_out = hit_q ? rd_data : '0;
	assign status   = st_q;
	assign count    = fill_q;
	assign is_empty = (fill_q == '0);

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FULL_CNT)
		else $error("fill count beyond capacity");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec && wr_en |=> fill_q == $past(fill_q) + 1'b1)
		else $error("accepted push did not grow the queue");

	a_rw_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && rd_en))
		else $error("slot write and read in the same cycle");

	a_hit_ok: assert property (@(posedge clk) disable iff (!arst_n)
		hit_q |-> st_q == ST_OK)
		else $error("read data flagged on a failed operation");

endmodule

[rtl/double_ended_queue_unit.sv]
// the result strobe done is registered as the controller leaves the execute state
// busy stays high for the whole operation, through the execute and the result state;
// the result state covers the registered slot read; start is taken only while not busy
// results are strobed for one cycle and cannot be held off by the receiver
// reset (arst_n low, asynchronous) clears the indices, fill count and controller;
// slot memory contents are not cleared and are only read once written
module double_ended_queue_unit
	import deq_pkg::*;
#(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [MODE_W-1:0]     mode,
	input  logic [DATA_WIDTH-1:0] data_in,
	output logic                  done,
	output logic [DATA_WIDTH-1:0] data_out,
	output logic [STATUS_W-1:0]   status,
	output logic [CW-1:0]         count,
	output logic                  is_empty
);

	ctl_cmd_t cmd;

	deq_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.done  (done),
		.cmd   (cmd)
	);

	deq_dp #(
		.DEPTH     (DEPTH),
		.DATA_WIDTH(DATA_WIDTH)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.mode    (mode),
		.data_in (data_in),
		.data_out(data_out),
		.status  (status),
		.count   (count),
		.is_empty(is_empty)
	);

endmodule
